/* rtl/hfm_pkg.sv */
// types, codes and constants shared by the heartbeat freshness monitor
`timescale 1ns / 1ps

package hfm_pkg;

  localparam int TIME_W  = 48;
  localparam int AGE_W   = TIME_W + 1;
  localparam int THR_W   = 32;
  localparam int SEQ_W   = 32;
  localparam int PID_W   = 32;
  localparam int GOOD_W  = 16;
  localparam int RST_W   = 32;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 32;

  // item kinds
  localparam logic [1:0] CMD_SNAPSHOT = 2'd0;
  localparam logic [1:0] CMD_FAILURE  = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;

  // health classes
  localparam logic [2:0] HEALTH_OK          = 3'd0;
  localparam logic [2:0] HEALTH_DELAYED     = 3'd1;
  localparam logic [2:0] HEALTH_STALE       = 3'd2;
  localparam logic [2:0] HEALTH_INVALID     = 3'd3;
  localparam logic [2:0] HEALTH_UNAVAILABLE = 3'd4;
  localparam logic [2:0] HEALTH_SCHEMA      = 3'd5;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_DELAYED     = 2'd0;
  localparam logic [CIDX_W-1:0] REG_STALE       = 2'd1;
  localparam logic [CIDX_W-1:0] REG_UNAVAILABLE = 2'd2;
  localparam logic [CIDX_W-1:0] REG_STABILIZE   = 2'd3;

  // reset values of the registers
  localparam logic [THR_W-1:0]  DELAYED_RESET     = 32'd1000;
  localparam logic [THR_W-1:0]  STALE_RESET       = 32'd3000;
  localparam logic [THR_W-1:0]  UNAVAILABLE_RESET = 32'd10000;
  localparam logic [GOOD_W-1:0] STABILIZE_RESET   = 16'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TIME_W-1:0] now_ms;
    logic [SEQ_W-1:0]  sequence_req;
    logic [PID_W-1:0]  producer_id;
    logic              error_schema;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        health;
    logic              duplicate;
    logic              regression;
    logic              decode_failed;
    logic [RST_W-1:0]  restarts;
    logic [GOOD_W-1:0] good_run;
  } out_word_t;

  typedef struct packed {
    logic [THR_W-1:0]  delay_limit;
    logic [THR_W-1:0]  stale_limit;
    logic [THR_W-1:0]  unavail_limit;
    logic [GOOD_W-1:0] settle_count;
  } cfg_t;

  typedef struct packed {
    logic              seen_valid;
    logic [SEQ_W-1:0]  prev_sequence;
    logic [PID_W-1:0]  prev_producer;
    logic [TIME_W-1:0] last_good_time;
    logic [GOOD_W-1:0] good_count;
    logic [RST_W-1:0]  restart_count;
    logic              failed_flag;
    logic              schema_error_flag;
    logic              dup_flag;
    logic              regress_flag;
  } mon_state_t;

endpackage

/* rtl/hfm_update.sv */
// per-word state update and health classification
`timescale 1ns / 1ps

module hfm_update (
  input  hfm_pkg::in_word_t   word,
  input  hfm_pkg::cfg_t       cfg,
  input  hfm_pkg::mon_state_t cur,
  output hfm_pkg::mon_state_t nxt,
  output hfm_pkg::out_word_t  result
);

  logic                            is_snap;
  logic                            is_fail;
  logic signed [hfm_pkg::AGE_W-1:0] age;
  logic                            over_delayed;
  logic                            over_stale;
  logic                            over_unavail;
  logic                            restart;
  logic                            dup;
  logic                            regress;
  logic [hfm_pkg::GOOD_W-1:0]      good_base;

  assign is_snap = (word.cmd == hfm_pkg::CMD_SNAPSHOT);
  assign is_fail = (word.cmd == hfm_pkg::CMD_FAILURE);

  // signed age against the previous good snapshot
  assign age = $signed({1'b0, word.now_ms}) - $signed({1'b0, cur.last_good_time});

  assign over_delayed = age > $signed({{(hfm_pkg::AGE_W-hfm_pkg::THR_W){1'b0}},
                                       cfg.delay_limit});
  assign over_stale   = age > $signed({{(hfm_pkg::AGE_W-hfm_pkg::THR_W){1'b0}},
                                       cfg.stale_limit});
  assign over_unavail = age > $signed({{(hfm_pkg::AGE_W-hfm_pkg::THR_W){1'b0}},
                                       cfg.unavail_limit});

  // snapshot sequence checks
  assign restart = cur.seen_valid && (word.producer_id != cur.prev_producer);
  assign dup     = cur.seen_valid && !restart && (word.sequence_req == cur.prev_sequence);
  assign regress = cur.seen_valid && !restart && !dup &&
                   (word.sequence_req < cur.prev_sequence);

  assign good_base = (restart || regress || (cur.seen_valid && over_stale)) ?
                     '0 : cur.good_count;

  // next state
  always_comb begin
    nxt = cur;
    if (is_snap) begin
      nxt.failed_flag       = 1'b0;
      nxt.schema_error_flag = 1'b0;
      nxt.dup_flag          = dup;
      nxt.regress_flag      = regress;
      if (restart && (cur.restart_count != '1)) begin
        nxt.restart_count = cur.restart_count + 1'b1;
      end
      if (!dup && !regress && (good_base != '1)) begin
        nxt.good_count = good_base + 1'b1;
      end else begin
        nxt.good_count = good_base;
      end
      nxt.seen_valid     = 1'b1;
      nxt.prev_sequence  = word.sequence_req;
      nxt.prev_producer  = word.producer_id;
      nxt.last_good_time = word.now_ms;
    end else if (is_fail) begin
      nxt.failed_flag       = 1'b1;
      nxt.schema_error_flag = word.error_schema;
      nxt.dup_flag          = 1'b0;
      nxt.regress_flag      = 1'b0;
      nxt.good_count        = '0;
    end
  end

  // health after the update; a snapshot leaves an age of zero
  always_comb begin
    result.duplicate     = nxt.dup_flag;
    result.regression    = nxt.regress_flag;
    result.decode_failed = nxt.failed_flag;
    result.restarts      = nxt.restart_count;
    result.good_run      = nxt.good_count;
    if (nxt.failed_flag && nxt.schema_error_flag) begin
      result.health = hfm_pkg::HEALTH_SCHEMA;
    end else if (nxt.failed_flag && !nxt.seen_valid) begin
      result.health = hfm_pkg::HEALTH_INVALID;
    end else if (!nxt.seen_valid) begin
      result.health = hfm_pkg::HEALTH_UNAVAILABLE;
    end else if (!is_snap && over_unavail) begin
      result.health = hfm_pkg::HEALTH_UNAVAILABLE;
    end else if (!is_snap && over_stale) begin
      result.health = hfm_pkg::HEALTH_STALE;
    end else if (!is_snap && over_delayed) begin
      result.health = hfm_pkg::HEALTH_DELAYED;
    end else if (nxt.good_count < cfg.settle_count) begin
      result.health = hfm_pkg::HEALTH_DELAYED;
    end else begin
      result.health = hfm_pkg::HEALTH_OK;
    end
  end

endmodule

/* rtl/heartbeat_freshness_monitor.sv */
// top level of the heartbeat freshness monitor
// Usage:
//   in_valid/in_ready/in_data carry one word per snapshot, decode failure or
//   query, each with its timestamp. out_valid/out_ready/out_data return one
//   result word per input word, in order: the health class, the duplicate,
//   regression and failure flags, the restart count and the good run.
//   cfg_we/cfg_index/cfg_wdata write the three age thresholds and the
//   stabilization count; write them only while no word is in flight.
// Path: a word accepted into the input register is evaluated against the
//   monitor state there and shows on out_data once it moves into the result
//   register, which it does when that register is empty or its word is taken.
// Throughput: one word per cycle while out_ready is high; the state update and classification is a
//   single pass of compares and counter increments between the input register
//   and the result register.
// Reset: rst clears the monitor state, both valid bits and restores the
//   threshold registers to their defaults.
// Stall: while out_ready is low the result holds; one more word is taken into
//   the input register, then in_ready drops until the result is taken.
`timescale 1ns / 1ps

module heartbeat_freshness_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hfm_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hfm_pkg::out_word_t           out_data,
  input  logic                         cfg_we,
  input  logic [hfm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [hfm_pkg::CDATA_W-1:0]  cfg_wdata
);

  hfm_pkg::cfg_t       cfg;
  hfm_pkg::mon_state_t state;
  hfm_pkg::mon_state_t state_next;
  hfm_pkg::in_word_t   in_reg;
  hfm_pkg::out_word_t  result;
  logic                in_reg_valid;
  logic                advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_reg_valid || advance;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_limit   <= hfm_pkg::DELAYED_RESET;
      cfg.stale_limit   <= hfm_pkg::STALE_RESET;
      cfg.unavail_limit <= hfm_pkg::UNAVAILABLE_RESET;
      cfg.settle_count  <= hfm_pkg::STABILIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hfm_pkg::REG_DELAYED:     cfg.delay_limit   <= cfg_wdata;
        hfm_pkg::REG_STALE:       cfg.stale_limit   <= cfg_wdata;
        hfm_pkg::REG_UNAVAILABLE: cfg.unavail_limit <= cfg_wdata;
        hfm_pkg::REG_STABILIZE:
          cfg.settle_count <= cfg_wdata[hfm_pkg::GOOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  hfm_update u_update (
    .word   (in_reg),
    .cfg    (cfg),
    .cur    (state),
    .nxt    (state_next),
    .result (result)
  );

  // monitor state advances as each word moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_reg_valid && advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_reg_valid && advance) begin
      out_data <= result;
    end
  end

endmodule

/* verif/tb.sv */
// self-checking testbench for the heartbeat freshness monitor
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 3000;
  localparam int         PHASE_WORDS = 90;
  localparam int         RUN_WORDS   = 50;
  localparam int         HOLD_AT     = 60;
  localparam int         HOLD_LEN    = 120;

  // freshness predictor and store of health words still due
  class health_scoreboard;
    hfm_pkg::cfg_t       cfg;
    hfm_pkg::mon_state_t st;
    hfm_pkg::out_word_t  health_due_q[$];
    int                  errors;
    int                  checked;
    int                  class_seen[8];

    function new();
      cfg = '{hfm_pkg::DELAYED_RESET, hfm_pkg::STALE_RESET, hfm_pkg::UNAVAILABLE_RESET,
              hfm_pkg::STABILIZE_RESET};
      st = '0;
      errors = 0;
      checked = 0;
      foreach (class_seen[i]) class_seen[i] = 0;
    endfunction

    // signed age of a timestamp against the last good snapshot
    function longint age_at(logic [hfm_pkg::TIME_W-1:0] now);
      return longint'(now) - longint'(st.last_good_time);
    endfunction

    function int pending();
      return health_due_q.size();
    endfunction

    // update the monitor state with an accepted word and queue its result
    function void note_word(hfm_pkg::in_word_t w);
      logic               restart;
      longint             age;
      hfm_pkg::out_word_t r;
      if (w.cmd == hfm_pkg::CMD_SNAPSHOT) begin
        restart = st.seen_valid && (w.producer_id != st.prev_producer);
        st.failed_flag = 1'b0;
        st.schema_error_flag = 1'b0;
        st.dup_flag = 1'b0;
        st.regress_flag = 1'b0;
        if (restart) begin
          if (st.restart_count != '1) st.restart_count = st.restart_count + 1'b1;
          st.good_count = '0;
        end else if (st.seen_valid) begin
          if (w.sequence_req == st.prev_sequence) begin
            st.dup_flag = 1'b1;
          end else if (w.sequence_req < st.prev_sequence) begin
            st.regress_flag = 1'b1;
            st.good_count = '0;
          end
        end
        // a long gap breaks the good run
        if (st.seen_valid && age_at(w.now_ms) > longint'(cfg.stale_limit))
          st.good_count = '0;
        if (!st.dup_flag && !st.regress_flag && st.good_count != '1)
          st.good_count = st.good_count + 1'b1;
        st.seen_valid = 1'b1;
        st.prev_sequence = w.sequence_req;
        st.prev_producer = w.producer_id;
        st.last_good_time = w.now_ms;
      end else if (w.cmd == hfm_pkg::CMD_FAILURE) begin
        st.failed_flag = 1'b1;
        st.schema_error_flag = w.error_schema;
        st.dup_flag = 1'b0;
        st.regress_flag = 1'b0;
        st.good_count = '0;
      end

      // health class after the update
      age = age_at(w.now_ms);
      if (st.failed_flag && st.schema_error_flag) r.health = hfm_pkg::HEALTH_SCHEMA;
      else if (st.failed_flag && !st.seen_valid) r.health = hfm_pkg::HEALTH_INVALID;
      else if (!st.seen_valid) r.health = hfm_pkg::HEALTH_UNAVAILABLE;
      else if (age > longint'(cfg.unavail_limit)) r.health = hfm_pkg::HEALTH_UNAVAILABLE;
      else if (age > longint'(cfg.stale_limit)) r.health = hfm_pkg::HEALTH_STALE;
      else if (age > longint'(cfg.delay_limit)) r.health = hfm_pkg::HEALTH_DELAYED;
      else if (st.good_count < cfg.settle_count) r.health = hfm_pkg::HEALTH_DELAYED;
      else r.health = hfm_pkg::HEALTH_OK;
      r.duplicate = st.dup_flag;
      r.regression = st.regress_flag;
      r.decode_failed = st.failed_flag;
      r.restarts = st.restart_count;
      r.good_run = st.good_count;
      health_due_q.push_back(r);
    endfunction

    // compare a returned word with the oldest prediction
    function void check_result(hfm_pkg::out_word_t got);
      hfm_pkg::out_word_t want;
      if (health_due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result word %h with none outstanding", got);
        return;
      end
      want = health_due_q.pop_front();
      checked++;
      class_seen[want.health]++;
      if (got.health !== want.health || got.duplicate !== want.duplicate ||
          got.regression !== want.regression || got.decode_failed !== want.decode_failed ||
          got.restarts !== want.restarts || got.good_run !== want.good_run) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d expected health %0d dup %b reg %b fail %b rst %0d good %0d",
                   checked, want.health, want.duplicate, want.regression,
                   want.decode_failed, want.restarts, want.good_run);
          $display("       got health %0d dup %b reg %b fail %b rst %0d good %0d",
                   got.health, got.duplicate, got.regression, got.decode_failed,
                   got.restarts, got.good_run);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  hfm_pkg::in_word_t            in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  hfm_pkg::out_word_t           out_data;
  logic                         cfg_we = 1'b0;
  logic [hfm_pkg::CIDX_W-1:0]   cfg_index = '0;
  logic [hfm_pkg::CDATA_W-1:0]  cfg_wdata = '0;

  health_scoreboard             sb = new();
  bit                           steady = 1'b0;
  int                           n_words = 0;
  int                           n_settings = 0;
  logic [hfm_pkg::TIME_W-1:0]   cur_time = '0;
  logic [hfm_pkg::SEQ_W-1:0]    cur_seq = '0;
  logic [hfm_pkg::PID_W-1:0]    cur_pid = '0;

  heartbeat_freshness_monitor u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic hfm_pkg::in_word_t word_of(logic [1:0] cmd,
                                                logic [hfm_pkg::TIME_W-1:0] now,
                                                logic [hfm_pkg::SEQ_W-1:0] seq,
                                                logic [hfm_pkg::PID_W-1:0] pid,
                                                logic schema);
    hfm_pkg::in_word_t w;
    w.cmd = cmd;
    w.now_ms = now;
    w.sequence_req = seq;
    w.producer_id = pid;
    w.error_schema = schema;
    return w;
  endfunction

  // time step, mostly around the current thresholds
  function automatic logic [hfm_pkg::TIME_W-1:0] time_step(bit calm);
    logic [hfm_pkg::TIME_W-1:0] d;
    if (calm && $urandom_range(0, 9) < 7) return hfm_pkg::TIME_W'($urandom_range(0, 40));
    case ($urandom_range(0, 9))
      0, 1:    d = hfm_pkg::TIME_W'(sb.cfg.delay_limit) + $urandom_range(0, 2) - 1;
      2, 3:    d = hfm_pkg::TIME_W'(sb.cfg.stale_limit) + $urandom_range(0, 2) - 1;
      4, 5:    d = hfm_pkg::TIME_W'(sb.cfg.unavail_limit) + $urandom_range(0, 2) - 1;
      6, 7:    d = hfm_pkg::TIME_W'($urandom_range(0, 40));
      8:       d = hfm_pkg::TIME_W'(0) - $urandom_range(1, 500);
      default: d = {16'($urandom), 32'($urandom)};
    endcase
    return d;
  endfunction

  // mostly well-formed snapshot streams, some failures, queries and noise
  function automatic hfm_pkg::in_word_t next_random_word();
    hfm_pkg::in_word_t w;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      w = word_of(hfm_pkg::CMD_SNAPSHOT, cur_time + time_step(1'b1),
                  cur_seq + $urandom_range(1, 3), cur_pid, 1'($urandom));
    end else if (pick < 65) begin
      w = word_of(hfm_pkg::CMD_SNAPSHOT, cur_time + time_step(1'b1), cur_seq, cur_pid,
                  1'b0);
    end else if (pick < 70) begin
      w = word_of(hfm_pkg::CMD_SNAPSHOT, cur_time + time_step(1'b0),
                  cur_seq - $urandom_range(1, 1000), cur_pid, 1'b0);
    end else if (pick < 75) begin
      w = word_of(hfm_pkg::CMD_SNAPSHOT, cur_time + time_step(1'b0),
                  $urandom_range(0, 10), $urandom, 1'b0);
    end else if (pick < 83) begin
      w = word_of(hfm_pkg::CMD_FAILURE, cur_time + time_step(1'b0), $urandom, $urandom,
                  1'($urandom));
    end else if (pick < 91) begin
      w = word_of(hfm_pkg::CMD_QUERY, cur_time + time_step(1'b0), $urandom, $urandom,
                  1'($urandom));
    end else if (pick < 94) begin
      w = word_of(CMD_UNUSED, cur_time + time_step(1'b0), $urandom, $urandom, 1'($urandom));
    end else begin
      w = word_of(2'($urandom), {16'($urandom), 32'($urandom)}, $urandom, $urandom,
                  1'($urandom));
    end
    cur_time = w.now_ms;
    if (w.cmd == hfm_pkg::CMD_SNAPSHOT) begin
      cur_seq = w.sequence_req;
      cur_pid = w.producer_id;
    end
    return w;
  endfunction

  // offer one word and wait for the handshake
  task automatic send_word(input hfm_pkg::in_word_t w);
    while (!steady && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    n_words++;
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic load_thresholds(input hfm_pkg::cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= hfm_pkg::REG_DELAYED;
    cfg_wdata <= c.delay_limit;
    @(posedge clk);
    cfg_index <= hfm_pkg::REG_STALE;
    cfg_wdata <= c.stale_limit;
    @(posedge clk);
    cfg_index <= hfm_pkg::REG_UNAVAILABLE;
    cfg_wdata <= c.unavail_limit;
    @(posedge clk);
    cfg_index <= hfm_pkg::REG_STABILIZE;
    cfg_wdata <= {16'($urandom), c.settle_count};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.cfg = c;
    n_settings++;
  endtask

  // result side: random stalls plus one long hold-off
  initial begin : result_sink
    int hold;
    int taken;
    hold = 0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        taken++;
        if (taken == HOLD_AT) hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // end the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    hfm_pkg::cfg_t              settings[6];
    logic [hfm_pkg::TIME_W-1:0] t;
    logic [hfm_pkg::SEQ_W-1:0]  seq;

    settings[0] = '{hfm_pkg::DELAYED_RESET, hfm_pkg::STALE_RESET,
                    hfm_pkg::UNAVAILABLE_RESET, hfm_pkg::STABILIZE_RESET};
    settings[1] = '{32'd0, 32'd0, 32'd0, 16'd0};
    settings[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF};
    settings[3] = '{32'd50000, 32'd2000, 32'd500, 16'd1};
    settings[4] = '{$urandom, $urandom, $urandom, 16'($urandom_range(0, 8))};
    settings[5] = '{$urandom_range(0, 20000), $urandom_range(0, 20000),
                    $urandom_range(0, 20000), 16'($urandom_range(0, 5))};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // nothing seen yet: query, unused code, both failure kinds
    send_word(word_of(hfm_pkg::CMD_QUERY, 48'd0, 32'd0, 32'd0, 1'b0));
    send_word(word_of(CMD_UNUSED, 48'd5, '1, '1, 1'b1));
    send_word(word_of(hfm_pkg::CMD_FAILURE, 48'd10, 32'd0, 32'd0, 1'b0));
    send_word(word_of(hfm_pkg::CMD_FAILURE, 48'd20, 32'd0, 32'd0, 1'b1));
    // stabilize, then duplicate and regression
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, 48'd100, 32'd0, 32'd7, 1'b0));
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, 48'd200, 32'd1, 32'd7, 1'b0));
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, 48'd300, 32'd2, 32'd7, 1'b0));
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, 48'd350, 32'd2, 32'd7, 1'b0));
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, 48'd400, 32'd1, 32'd7, 1'b0));
    // ages on each side of the delayed and stale thresholds, above the unavailable one, and a negative age
    send_word(word_of(hfm_pkg::CMD_QUERY, 48'd1400, 32'd0, 32'd0, 1'b0));
    send_word(word_of(hfm_pkg::CMD_QUERY, 48'd1401, 32'd0, 32'd0, 1'b0));
    send_word(word_of(hfm_pkg::CMD_QUERY, 48'd3400, 32'd0, 32'd0, 1'b0));
    send_word(word_of(hfm_pkg::CMD_QUERY, 48'd3401, 32'd0, 32'd0, 1'b0));
    send_word(word_of(hfm_pkg::CMD_QUERY, 48'd10401, 32'd0, 32'd0, 1'b0));
    send_word(word_of(hfm_pkg::CMD_QUERY, 48'd399, 32'd0, 32'd0, 1'b0));
    // gap reset, restart, failures after a snapshot
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, 48'd3500, 32'd5, 32'd7, 1'b0));
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, 48'd3600, 32'd6, 32'd9, 1'b0));
    send_word(word_of(hfm_pkg::CMD_FAILURE, 48'd3700, 32'd0, 32'd0, 1'b0));
    send_word(word_of(hfm_pkg::CMD_FAILURE, 48'd3800, 32'd0, 32'd0, 1'b1));
    // field extremes and time running backwards
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, '1, '1, '1, 1'b1));
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, 48'd0, 32'd0, '1, 1'b0));
    send_word(word_of(hfm_pkg::CMD_QUERY, '1, 32'd0, 32'd0, 1'b0));
    send_word(word_of(CMD_UNUSED, 48'd0, '1, 32'd0, 1'b1));
    drain();

    cur_time = 48'd0;
    cur_seq = 32'd0;
    cur_pid = '1;
    load_thresholds(settings[0]);
    repeat (PHASE_WORDS) send_word(next_random_word());
    drain();

    // long unbroken run of good samples with no idling on either side
    load_thresholds('{hfm_pkg::DELAYED_RESET, hfm_pkg::STALE_RESET,
                      hfm_pkg::UNAVAILABLE_RESET, 16'hFFFF});
    steady = 1'b1;
    t = cur_time;
    seq = cur_seq;
    send_word(word_of(hfm_pkg::CMD_SNAPSHOT, t, seq, cur_pid, 1'b0));
    for (int i = 0; i < RUN_WORDS; i++) begin
      t = t + 1'b1;
      seq = seq + 1'b1;
      send_word(word_of(hfm_pkg::CMD_SNAPSHOT, t, seq, cur_pid, 1'b0));
    end
    send_word(word_of(hfm_pkg::CMD_QUERY, t, 32'd0, 32'd0, 1'b0));
    drain();
    steady = 1'b0;
    cur_time = t;
    cur_seq = seq;

    for (int p = 1; p < 6; p++) begin
      load_thresholds(settings[p]);
      repeat (PHASE_WORDS) send_word(next_random_word());
      drain();
    end

    repeat (4) @(posedge clk);
    $display("covered %0d words and %0d results over %0d register settings",
             n_words, sb.checked, n_settings);
    $display("classes ok %0d delayed %0d stale %0d invalid %0d unavail %0d schema %0d",
             sb.class_seen[hfm_pkg::HEALTH_OK], sb.class_seen[hfm_pkg::HEALTH_DELAYED],
             sb.class_seen[hfm_pkg::HEALTH_STALE], sb.class_seen[hfm_pkg::HEALTH_INVALID],
             sb.class_seen[hfm_pkg::HEALTH_UNAVAILABLE],
             sb.class_seen[hfm_pkg::HEALTH_SCHEMA]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
